// File: design/vdr_pkg.sv
`timescale 1ns / 1ps

package vdr_pkg;

    // fixed sizes of the pose datapath
    localparam int ANGLE_BITS   = 16;
    localparam int POS_BITS     = 32;
    localparam int CORDIC_STEPS = 16;

    localparam int PHASE_W  = 32;
    localparam int HEAD_SH  = PHASE_W - ANGLE_BITS;
    localparam int CW       = 34;   // cordic x/y width
    localparam int ZW       = 33;   // cordic angle accumulator width
    localparam int CNT_W    = 5;
    localparam int NUM_W    = 60;   // divider dividend / quotient width
    localparam int DEN_W    = 32;   // divider divisor width
    localparam int DCNT_W   = 6;
    localparam int DX_W     = 37;
    localparam int SUM_W    = ((POS_BITS > DX_W) ? POS_BITS : DX_W) + 1;

    localparam logic signed [15:0] STEER_LIMIT   = 16'sd16002;
    localparam logic [21:0]        RAD_TO_TURN   = 22'd2670177;
    localparam logic [CW-1:0]      CORDIC_START  = CW'(652032874);
    localparam logic [22:0]        TAN_CAP       = 23'h3FFFFF;

    localparam logic signed [SUM_W-1:0] POS_MAX = SUM_W'((64'sd1 <<< (POS_BITS - 1)) - 64'sd1);
    localparam logic signed [SUM_W-1:0] POS_MIN = SUM_W'(-(64'sd1 <<< (POS_BITS - 1)));

    // register indexes
    localparam logic REG_MODE      = 1'b0;
    localparam logic REG_WHEELBASE = 1'b1;

    // arctangent of 2^-i, 2^32 per turn
    function automatic logic [31:0] atan_turn(input logic [CNT_W-1:0] i);
        logic [31:0] r;
        case (i)
            5'd0:    r = 32'h20000000;
            5'd1:    r = 32'h12E4051E;
            5'd2:    r = 32'h09FB385B;
            5'd3:    r = 32'h051111D4;
            5'd4:    r = 32'h028B0D43;
            5'd5:    r = 32'h0145D7E1;
            5'd6:    r = 32'h00A2F61E;
            5'd7:    r = 32'h00517C55;
            5'd8:    r = 32'h0028BE53;
            5'd9:    r = 32'h00145F2F;
            5'd10:   r = 32'h000A2F98;
            5'd11:   r = 32'h000517CC;
            5'd12:   r = 32'h00028BE6;
            5'd13:   r = 32'h000145F3;
            5'd14:   r = 32'h0000A2F9;
            5'd15:   r = 32'h0000517C;
            5'd16:   r = 32'h000028BE;
            5'd17:   r = 32'h0000145F;
            5'd18:   r = 32'h00000A2F;
            5'd19:   r = 32'h00000517;
            5'd20:   r = 32'h0000028B;
            5'd21:   r = 32'h00000145;
            5'd22:   r = 32'h000000A2;
            5'd23:   r = 32'h00000051;
            default: r = 32'h00000000;
        endcase
        return r;
    endfunction

endpackage

// File: design/vdr_cordic.sv
`timescale 1ns / 1ps

module vdr_cordic
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [vdr_pkg::PHASE_W-1:0]   phase,
    output logic                          done,
    output logic signed [vdr_pkg::CW-1:0] cos_out,
    output logic signed [vdr_pkg::CW-1:0] sin_out
);

    logic signed [vdr_pkg::CW-1:0]    x_reg, x_next;
    logic signed [vdr_pkg::CW-1:0]    y_reg, y_next;
    logic signed [vdr_pkg::ZW-1:0]    z_reg, z_next;
    logic [vdr_pkg::CNT_W-1:0]        cnt_reg, cnt_next;
    logic                             busy_reg, busy_next;
    logic                             done_reg, done_next;

    logic signed [vdr_pkg::ZW-1:0]    z_in;
    logic signed [vdr_pkg::CW-1:0]    xs, ys;
    logic signed [vdr_pkg::ZW-1:0]    atan_z;

    assign z_in   = vdr_pkg::ZW'(signed'(phase));
    assign xs     = x_reg >>> cnt_reg;
    assign ys     = y_reg >>> cnt_reg;
    assign atan_z = signed'({1'b0, vdr_pkg::atan_turn(cnt_reg)});

    // one rotation step per cycle, quadrant fold on start
    always_comb
    begin
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            x_next    = signed'(vdr_pkg::CORDIC_START);
            y_next    = '0;
            z_next    = z_in;
            cnt_next  = '0;
            busy_next = 1'b1;
            if (z_in > vdr_pkg::ZW'(33'sh040000000))
            begin
                z_next = z_in - vdr_pkg::ZW'(33'sh080000000);
                x_next = -signed'(vdr_pkg::CORDIC_START);
            end
            else if (z_in < -vdr_pkg::ZW'(33'sh040000000))
            begin
                z_next = z_in + vdr_pkg::ZW'(33'sh080000000);
                x_next = -signed'(vdr_pkg::CORDIC_START);
            end
        end
        else if (busy_reg)
        begin
            if (!z_reg[vdr_pkg::ZW-1])
            begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - atan_z;
            end
            else
            begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + atan_z;
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == vdr_pkg::CNT_W'(vdr_pkg::CORDIC_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign done    = done_reg;
    assign cos_out = x_reg;
    assign sin_out = y_reg;

endmodule

// File: design/vdr_div.sv
`timescale 1ns / 1ps

module vdr_div
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [vdr_pkg::NUM_W-1:0]   dividend,
    input  logic [vdr_pkg::DEN_W-1:0]   divisor,
    output logic                        done,
    output logic [vdr_pkg::NUM_W-1:0]   quotient
);

    logic [vdr_pkg::NUM_W-1:0]  q_reg, q_next;
    logic [vdr_pkg::DEN_W:0]    rem_reg, rem_next;
    logic [vdr_pkg::DEN_W-1:0]  den_reg, den_next;
    logic [vdr_pkg::DCNT_W-1:0] cnt_reg, cnt_next;
    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [vdr_pkg::DEN_W:0]    trial;

    assign trial = {rem_reg[vdr_pkg::DEN_W-1:0], q_reg[vdr_pkg::NUM_W-1]};

    // restoring division, one quotient bit per cycle
    always_comb
    begin
        q_next    = q_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            q_next    = dividend;
            rem_next  = '0;
            den_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = trial - {1'b0, den_reg};
                q_next   = {q_reg[vdr_pkg::NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                q_next   = {q_reg[vdr_pkg::NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == vdr_pkg::DCNT_W'(vdr_pkg::NUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

// File: design/vehicle_dead_reckoning.sv
`timescale 1ns / 1ps
// particle mode: each word runs the heading update and the 16-step cordic
// bicycle mode: each word runs two divider passes and two cordic runs around
//   one shared multiplier
// one word at a time; a finished word waits in the output register for m_tready
// reset clears pose to zero, mode to particle, wheelbase to 1.0

module vehicle_dead_reckoning
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // speed[15:0], turn_angle[31:16]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // pos_x[31:0], pos_y[63:32], heading[79:64],
                                   // pos_saturated[80], zero pad
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    typedef enum logic [13:0]
    {
        S_IDLE = 14'b00000000000001,
        S_C1   = 14'b00000000000010,
        S_D1   = 14'b00000000000100,
        S_M1   = 14'b00000000001000,
        S_M2   = 14'b00000000010000,
        S_M3   = 14'b00000000100000,
        S_M4   = 14'b00000001000000,
        S_D2   = 14'b00000010000000,
        S_HEAD = 14'b00000100000000,
        S_C2   = 14'b00001000000000,
        S_MX   = 14'b00010000000000,
        S_MY   = 14'b00100000000000,
        S_UPD  = 14'b01000000000000,
        S_OUT  = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;

    logic                                 mode_reg;
    logic [15:0]                          wheelbase_reg;
    logic signed [vdr_pkg::POS_BITS-1:0]  x_reg, x_next;
    logic signed [vdr_pkg::POS_BITS-1:0]  y_reg, y_next;
    logic [vdr_pkg::ANGLE_BITS-1:0]       heading_reg;
    logic signed [15:0]                   v_reg;
    logic                                 s_neg_reg;
    logic [22:0]                          t_reg;
    logic [31:0]                          delta_reg;
    logic signed [58:0]                   prod_reg;
    logic [40:0]                          lo_reg;
    logic [40:0]                          hi_reg;
    logic signed [vdr_pkg::DX_W-1:0]      dx_reg;
    logic                                 sat_reg;
    logic                                 out_valid_reg;
    logic [87:0]                          out_data_reg;

    logic                                 s_accept;
    logic signed [15:0]                   in_speed;
    logic signed [15:0]                   in_turn;
    logic signed [15:0]                   steer;
    logic [15:0]                          abs_v;

    logic                                 cord_start;
    logic [vdr_pkg::PHASE_W-1:0]          cord_phase;
    logic                                 cord_done;
    logic signed [vdr_pkg::CW-1:0]        cord_cos;
    logic signed [vdr_pkg::CW-1:0]        cord_sin;

    logic                                 div_start;
    logic [vdr_pkg::NUM_W-1:0]            div_num;
    logic [vdr_pkg::DEN_W-1:0]            div_den;
    logic                                 div_done;
    logic [vdr_pkg::NUM_W-1:0]            div_q;

    logic signed [34:0]                   mul_a;
    logic signed [23:0]                   mul_b;
    logic signed [58:0]                   mul_p;

    logic signed [vdr_pkg::CW-1:0]        c_clamped;
    logic [vdr_pkg::CW-1:0]               s_abs;
    logic [31:0]                          phase_now;
    logic [31:0]                          phase_sum;
    logic [vdr_pkg::ANGLE_BITS-1:0]       heading_new;
    logic [31:0]                          phase_new;
    logic [15:0]                          len;
    logic [31:0]                          mag;
    logic signed [58:0]                   round_sum;
    logic signed [vdr_pkg::DX_W-1:0]      dy;
    logic signed [vdr_pkg::SUM_W-1:0]     x_sum;
    logic signed [vdr_pkg::SUM_W-1:0]     y_sum;
    logic                                 sat_now;
    logic [31:0]                          out_x;
    logic [31:0]                          out_y;
    logic [15:0]                          out_head;

    assign s_accept = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign in_speed = signed'(s_tdata[15:0]);
    assign in_turn  = signed'(s_tdata[31:16]);
    assign abs_v    = v_reg[15] ? 16'(-v_reg) : 16'(v_reg);

    // steer clamp for bicycle mode
    always_comb
    begin
        if (in_turn > vdr_pkg::STEER_LIMIT)
            steer = vdr_pkg::STEER_LIMIT;
        else if (in_turn < -vdr_pkg::STEER_LIMIT)
            steer = -vdr_pkg::STEER_LIMIT;
        else
            steer = in_turn;
    end

    // heading arithmetic on the 32-bit phase
    assign phase_now   = {heading_reg, {vdr_pkg::HEAD_SH{1'b0}}};
    assign phase_sum   = phase_now + delta_reg;
    assign heading_new = phase_sum[31:vdr_pkg::HEAD_SH];
    assign phase_new   = {heading_new, {vdr_pkg::HEAD_SH{1'b0}}};

    // tan inputs from the steer cordic
    assign c_clamped = (cord_cos < vdr_pkg::CW'(1)) ? vdr_pkg::CW'(1) : cord_cos;
    assign s_abs     = cord_sin[vdr_pkg::CW-1] ? vdr_pkg::CW'(-cord_sin)
                                                : vdr_pkg::CW'(cord_sin);
    assign len       = (wheelbase_reg == 16'd0) ? 16'd1 : wheelbase_reg;
    assign mag       = div_q[31:0];

    // cordic shared by steer and heading
    assign cord_start = (state_reg == S_IDLE && s_accept && mode_reg) ||
                        (state_reg == S_HEAD);
    assign cord_phase = (state_reg == S_HEAD) ? phase_new : {steer, 16'h0000};

    vdr_cordic u_cordic
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cord_start),
        .phase   (cord_phase),
        .done    (cord_done),
        .cos_out (cord_cos),
        .sin_out (cord_sin)
    );

    // divider shared by tan and heading rate
    assign div_start = (state_reg == S_C1 && cord_done) || (state_reg == S_M4);
    always_comb
    begin
        if (state_reg == S_M4)
        begin
            div_num = {hi_reg[40:0], 19'b0} + vdr_pkg::NUM_W'(lo_reg);
            div_den = {8'b0, len, 8'b0};
        end
        else
        begin
            div_num = vdr_pkg::NUM_W'({s_abs, 16'h0000});
            div_den = c_clamped[31:0];
        end
    end

    vdr_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (div_den),
        .done     (div_done),
        .quotient (div_q)
    );

    // one shared multiplier, operands picked by state
    always_comb
    begin
        case (state_reg)
            S_M1:
            begin
                mul_a = signed'({12'b0, t_reg});
                mul_b = signed'({8'b0, abs_v});
            end
            S_M2:
            begin
                mul_a = signed'({13'b0, vdr_pkg::RAD_TO_TURN});
                mul_b = signed'({5'b0, prod_reg[18:0]});
            end
            S_M3:
            begin
                mul_a = signed'({13'b0, vdr_pkg::RAD_TO_TURN});
                mul_b = signed'({5'b0, prod_reg[37:19]});
            end
            S_MY:
            begin
                mul_a = 35'(cord_sin);
                mul_b = 24'(v_reg);
            end
            default:
            begin
                mul_a = 35'(cord_cos);
                mul_b = 24'(v_reg);
            end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // rounding of the position steps and saturating update
    assign round_sum = prod_reg + 59'sd2097152;
    assign dy        = round_sum[58:22];
    assign x_sum     = vdr_pkg::SUM_W'(x_reg) + vdr_pkg::SUM_W'(dx_reg);
    assign y_sum     = vdr_pkg::SUM_W'(y_reg) + vdr_pkg::SUM_W'(dy);

    always_comb
    begin
        sat_now = 1'b0;
        if (x_sum > vdr_pkg::POS_MAX)
        begin
            x_next  = vdr_pkg::POS_BITS'(vdr_pkg::POS_MAX);
            sat_now = 1'b1;
        end
        else if (x_sum < vdr_pkg::POS_MIN)
        begin
            x_next  = vdr_pkg::POS_BITS'(vdr_pkg::POS_MIN);
            sat_now = 1'b1;
        end
        else
            x_next = vdr_pkg::POS_BITS'(x_sum);
        if (y_sum > vdr_pkg::POS_MAX)
        begin
            y_next  = vdr_pkg::POS_BITS'(vdr_pkg::POS_MAX);
            sat_now = 1'b1;
        end
        else if (y_sum < vdr_pkg::POS_MIN)
        begin
            y_next  = vdr_pkg::POS_BITS'(vdr_pkg::POS_MIN);
            sat_now = 1'b1;
        end
        else
            y_next = vdr_pkg::POS_BITS'(y_sum);
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (s_accept)
                    state_next = mode_reg ? S_C1 : S_HEAD;
            S_C1:
                if (cord_done)
                    state_next = S_D1;
            S_D1:
                if (div_done)
                    state_next = S_M1;
            S_M1:    state_next = S_M2;
            S_M2:    state_next = S_M3;
            S_M3:    state_next = S_M4;
            S_M4:    state_next = S_D2;
            S_D2:
                if (div_done)
                    state_next = S_HEAD;
            S_HEAD:  state_next = S_C2;
            S_C2:
                if (cord_done)
                    state_next = S_MX;
            S_MX:    state_next = S_MY;
            S_MY:    state_next = S_UPD;
            S_UPD:   state_next = S_OUT;
            S_OUT:
                if (!out_valid_reg || m_tready)
                    state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // control and pose state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mode_reg      <= 1'b0;
            wheelbase_reg <= 16'd256;
            x_reg         <= '0;
            y_reg         <= '0;
            heading_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    vdr_pkg::REG_MODE:      mode_reg      <= cfg_data[0];
                    vdr_pkg::REG_WHEELBASE: wheelbase_reg <= cfg_data;
                    default:                mode_reg      <= mode_reg;
                endcase
            end
            if (state_reg == S_HEAD)
                heading_reg <= heading_new;
            if (state_reg == S_UPD)
            begin
                x_reg <= x_next;
                y_reg <= y_next;
            end
            if (state_reg == S_OUT && (!out_valid_reg || m_tready))
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_x    = 32'(x_reg);
    assign out_y    = 32'(y_reg);
    assign out_head = phase_now[31:16];

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            v_reg     <= in_speed;
            delta_reg <= {s_tdata[31:16], 16'h0000};
        end
        if (state_reg == S_C1 && cord_done)
            s_neg_reg <= cord_sin[vdr_pkg::CW-1];
        if (state_reg == S_D1 && div_done)
            t_reg <= (div_q > vdr_pkg::NUM_W'(vdr_pkg::TAN_CAP)) ? vdr_pkg::TAN_CAP
                                                                : div_q[22:0];
        if (state_reg == S_M1 || state_reg == S_MX || state_reg == S_MY)
            prod_reg <= mul_p;
        if (state_reg == S_M2)
            lo_reg <= mul_p[40:0];
        if (state_reg == S_M3)
            hi_reg <= mul_p[40:0];
        if (state_reg == S_D2 && div_done)
            delta_reg <= (v_reg[15] != s_neg_reg) ? (32'd0 - mag) : mag;
        if (state_reg == S_MY)
            dx_reg <= round_sum[58:22];
        if (state_reg == S_UPD)
            sat_reg <= sat_now;
        if (state_reg == S_OUT && (!out_valid_reg || m_tready))
            out_data_reg <= {7'b0, sat_reg, out_head, out_y, out_x};
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // checks on the sequencer
    a_cord_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        cord_done |-> (state_reg == S_C1 || state_reg == S_C2))
        else $error("cordic finished outside a cordic wait state");

    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_D1 || state_reg == S_D2))
        else $error("divider finished outside a divide wait state");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept |=> (state_reg != S_IDLE))
        else $error("sequencer stayed idle after taking a word");

    a_particle_path: assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && !mode_reg) |=> (state_reg == S_HEAD))
        else $error("particle word did not go straight to heading update");

endmodule
